// ===== design/assert_macros.svh =====
// Concurrent assertion helpers. Both expect clk in scope; SRPQ_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define SRPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define SRPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRPQ_ASSERT(lbl, prop, msg)
`define SRPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/srpq_pkg.sv =====
package srpq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 16;
	localparam int KEY_W     = 2;
	localparam int OCC_W     = 5;
	localparam int IN_W      = 24;	// 19 payload bits, padded to bytes
	localparam int OUT_W     = 32;	// 25 payload bits, padded to bytes

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic    ins;		// shift new entry in
		logic    rem;		// pop head
		logic    load;		// capture result beat
		status_t status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
	} stat_t;

endpackage

// ===== design/srpq_dp.sv =====
module srpq_dp #(
	parameter int DEPTH = srpq_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  srpq_pkg::cmd_t           cmd,
	input  logic [srpq_pkg::ID_W-1:0]  in_id,
	input  logic [srpq_pkg::KEY_W-1:0] in_key,
	output srpq_pkg::stat_t          stat,
	output logic [CW-1:0]            count,
	output srpq_pkg::status_t        res_status,
	output logic [srpq_pkg::ID_W-1:0]  res_id,
	output logic [srpq_pkg::KEY_W-1:0] res_key,
	output logic [srpq_pkg::OCC_W-1:0] res_occ
);
	import srpq_pkg::*;

	logic [ID_W-1:0]  ids_q  [DEPTH];
	logic [KEY_W-1:0] keys_q [DEPTH];
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic [DEPTH-1:0] ge;		// valid cell whose key >= new key

	assign count      = count_q;
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins)
			count_nxt = count_q + 1'b1;
		else if (cmd.rem)
			count_nxt = count_q - 1'b1;
	end

	// keys are sorted, so ge is a thermometer over the valid cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ge[i] = (CW'(i) < count_q) && (keys_q[i] >= in_key);

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
					ids_q[i]  <= ids_q[(i > 0) ? i - 1 : 0];
					keys_q[i] <= keys_q[(i > 0) ? i - 1 : 0];
				end else if (ge[i] || CW'(i) == count_q) begin
					ids_q[i]  <= in_id;
					keys_q[i] <= in_key;
				end
			end else if (cmd.rem && i < DEPTH - 1) begin
				ids_q[i]  <= ids_q[(i < DEPTH - 1) ? i + 1 : i];
				keys_q[i] <= keys_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status <= cmd.status;
			res_id     <= cmd.rem ? ids_q[0] : '0;
			res_key    <= cmd.rem ? keys_q[0] : '0;
			res_occ    <= OCC_W'(count_nxt);
		end
	end

endmodule

// ===== design/srpq_ctrl.sv =====
module srpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            m_tready,
	input  logic            opcode,
	input  srpq_pkg::stat_t stat,
	output logic            s_tready,
	output logic            m_tvalid,
	output srpq_pkg::cmd_t  cmd
);
	import srpq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	// output slot frees up in the same cycle it is taken
	assign s_tready = (state_q == S_IDLE) || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_HOLD);

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.status = ST_OK;
		if (accept) begin
			if (opcode == OP_INSERT) begin
				if (stat.full)
					cmd.status = ST_FULL;
				else
					cmd.ins = 1'b1;
			end else begin
				if (stat.empty)
					cmd.status = ST_EMPTY;
				else
					cmd.rem = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_HOLD;
				S_HOLD: if (m_tready && !accept) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue of (id, key) entries, smallest key at the head.
// Input stream (s_*): one beat is one command. opcode 0 inserts patient_id with
// priority_key in front of the first stored entry with key >= its own, so equal
// keys leave newest first; opcode 1 pops the head entry.
// Output stream (m_*): exactly one beat per command, carrying status (ok, remove
// from empty, insert into full), the popped id/key (zero unless a pop
// happened) and the occupancy after the command.
// Latency: the result beat is valid the cycle after the command is taken.
// Throughput: one command per cycle while m_tready is high. Every storage cell
// compares its key to the new key in parallel and shifts in the same cycle, so
// the time a queue update takes does not depend on the fill level.
// Stall: a single output register holds the pending result; while m_tready is
// low the result is held and s_tready drops, and the slot is refilled in the
// same cycle it is taken.
// Reset: arst_n clears the occupancy and the output valid; stored entries are
// not cleared since only slots below the occupancy are ever read.
`include "assert_macros.svh"

module sorted_priority_queue #(
	parameter int DEPTH = srpq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [0] opcode, [16:1] patient_id, [18:17] priority_key, rest zero
	input  logic [srpq_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [1:0] status, [17:2] out_id, [19:18] out_key, [24:20] occupancy, rest zero
	output logic [srpq_pkg::OUT_W-1:0] m_tdata
);
	import srpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cmd_t              cmd;
	stat_t             stat;
	logic [CW-1:0]     count;
	status_t           res_status;
	logic [ID_W-1:0]   res_id;
	logic [KEY_W-1:0]  res_key;
	logic [OCC_W-1:0]  res_occ;

	logic              opcode;
	logic [ID_W-1:0]   patient_id;
	logic [KEY_W-1:0]  priority_key;

	assign opcode       = s_tdata[0];
	assign patient_id   = s_tdata[16:1];
	assign priority_key = s_tdata[18:17];

	srpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.opcode   (opcode),
		.stat     (stat),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	srpq_dp #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_id      (patient_id),
		.in_key     (priority_key),
		.stat       (stat),
		.count      (count),
		.res_status (res_status),
		.res_id     (res_id),
		.res_key    (res_key),
		.res_occ    (res_occ)
	);

	assign m_tdata = {7'd0, res_occ, res_key, res_id, res_status};

	// occupancy never runs past the cell count
	`SRPQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "occupancy above depth")
	// every accepted command yields a pending result beat
	`SRPQ_ASSERT(a_beat_follows, s_tvalid && s_tready |=> m_tvalid, "no result after accept")
	// a pop from an empty queue reports it and leaves occupancy at zero
	`SRPQ_ASSERT(a_empty_pop, s_tvalid && s_tready && opcode == OP_REMOVE && stat.empty |=> m_tdata[1:0] == ST_EMPTY && count == '0, "empty pop mis-reported")
	// accepted insert with room grows the queue by one
	`SRPQ_ASSERT(a_insert_grows, s_tvalid && s_tready && opcode == OP_INSERT && !stat.full |=> count == $past(count) + 1'b1, "insert did not grow queue")
	// no result beat can be shown while reset is held
	`SRPQ_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "valid during reset")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import srpq_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int HOLD_LEN   = 60;		// long output stall, in cycles
	localparam int RAND_ITEMS = 400;	// per idling phase

	// result beat as laid out on m_tdata, lowest field last
	typedef struct packed {
		logic [OCC_W-1:0] occ;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
		status_t          status;
	} result_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shadow queue, sorted by ascending key, head at index 0
	logic [ID_W-1:0]  shadow_id  [DEPTH];
	logic [KEY_W-1:0] shadow_key [DEPTH];
	int               shadow_cnt = 0;

	result_t pending_results[$];

	int errors       = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_reqs    = 0;	// bumped by a test to ask for one long output stall

	// tallies for the summary
	int n_insert     = 0;
	int n_refused    = 0;
	int n_remove     = 0;
	int n_empty      = 0;
	int peak_fill    = 0;
	int input_stalls = 0;

	// Applies one command to the shadow queue and returns the result beat it
	// should produce. Inserts go in front of the first entry with key >= own.
	function automatic result_t apply_queue_cmd(logic op, logic [ID_W-1:0] id,
			logic [KEY_W-1:0] key);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		r.status = ST_OK;
		if (op == OP_INSERT) begin
			if (shadow_cnt >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_cnt && shadow_key[pos] < key)
					pos++;
				for (i = shadow_cnt; i > pos; i--) begin
					shadow_id[i]  = shadow_id[i-1];
					shadow_key[i] = shadow_key[i-1];
				end
				shadow_id[pos]  = id;
				shadow_key[pos] = key;
				shadow_cnt++;
			end
		end else begin
			if (shadow_cnt == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.id  = shadow_id[0];
				r.key = shadow_key[0];
				for (i = 1; i < shadow_cnt; i++) begin
					shadow_id[i-1]  = shadow_id[i];
					shadow_key[i-1] = shadow_key[i];
				end
				shadow_cnt--;
			end
		end
		r.occ = shadow_cnt[OCC_W-1:0];
		return r;
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Scoreboard: predicts on each accepted command beat, checks each result beat
	// against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				input_stalls++;
			if (s_tvalid && s_tready) begin
				want = apply_queue_cmd(s_tdata[0], s_tdata[16:1], s_tdata[18:17]);
				pending_results.push_back(want);
				if (s_tdata[0] == OP_INSERT) begin
					n_insert++;
					if (want.status == ST_FULL)
						n_refused++;
				end else begin
					n_remove++;
					if (want.status == ST_EMPTY)
						n_empty++;
				end
				if (shadow_cnt > peak_fill)
					peak_fill = shadow_cnt;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[24:0];
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result beat %0h with nothing expected", $time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					report_field("status",    want.status, got.status);
					report_field("out_id",    want.id,     got.id);
					report_field("out_key",   want.key,    got.key);
					report_field("occupancy", want.occ,    got.occ);
				end
			end
		end
	end

	// Output side: random backpressure, plus a long stall on request.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen++;
				hold_left = HOLD_LEN - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offers one command beat and returns once it has been taken.
	task automatic send_cmd(logic op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, key, id, op};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_remove();
		send_cmd(OP_REMOVE, '1, '1);	// payload on a remove is don't-care
		send_cmd(OP_REMOVE, '0, '0);
		release_input();
	endtask

	// Mixed keys with ties: ties must leave newest first.
	task automatic test_ordering();
		send_cmd(OP_INSERT, 16'h1111, 2'd2);
		send_cmd(OP_INSERT, 16'h2222, 2'd0);
		send_cmd(OP_INSERT, 16'h3333, 2'd3);
		send_cmd(OP_INSERT, 16'h4444, 2'd2);
		send_cmd(OP_INSERT, 16'hFFFF, 2'd1);
		send_cmd(OP_INSERT, 16'h0000, 2'd0);
		repeat (6) send_cmd(OP_REMOVE, '0, '0);
		release_input();
	endtask

	// Fill up, overflow, pop one, refill, then drain past empty.
	task automatic test_full_queue();
		for (int i = 0; i < DEPTH; i++)
			send_cmd(OP_INSERT, (i % 2) ? 16'hAAAA : 16'h5555, KEY_W'($urandom_range(3)));
		send_cmd(OP_INSERT, 16'hFFFF, 2'd3);
		send_cmd(OP_INSERT, 16'h0000, 2'd0);
		send_cmd(OP_REMOVE, '0, '0);
		send_cmd(OP_INSERT, 16'hFFFF, 2'd0);
		repeat (DEPTH + 1) send_cmd(OP_REMOVE, '0, '0);
		release_input();
	endtask

	// Output held off for a long stretch while inputs keep coming, so the
	// result register fills and the input side must stall.
	task automatic test_backpressure();
		snd_idle_pct = 0;
		hold_reqs++;
		for (int i = 0; i < 12; i++)
			send_cmd(OP_INSERT, ID_W'($urandom), KEY_W'($urandom_range(3)));
		repeat (12) send_cmd(OP_REMOVE, '0, '0);
		release_input();
	endtask

	// Bursts that lean toward filling or draining so the queue swings between
	// empty and full; some bursts pin a single key to pile up ties.
	task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
		int sent;
		int burst;
		int ins_pct;
		int one_key;
		logic [KEY_W-1:0] pinned;
		logic [KEY_W-1:0] k;
		logic op;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_items) begin
			burst   = $urandom_range(40, 4);
			ins_pct = ($urandom_range(2) == 0) ? 15 : ($urandom_range(1) ? 50 : 85);
			one_key = ($urandom_range(3) == 0);
			pinned  = KEY_W'($urandom_range(3));
			for (int j = 0; j < burst && sent < n_items; j++) begin
				op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
				k  = one_key ? pinned : KEY_W'($urandom_range(3));
				send_cmd(op, ID_W'($urandom), k);
				sent++;
			end
		end
		release_input();
		wait_drained();
	endtask

	initial begin
		// start released, then assert, so the reset edge is always seen
		arst_n   = 1'b1;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 20;
		rcv_idle_pct = 20;
		test_empty_remove();
		test_ordering();
		test_full_queue();
		wait_drained();
		test_backpressure();
		wait_drained();

		test_random_traffic(RAND_ITEMS, 28, 50);
		test_random_traffic(RAND_ITEMS, 50, 28);
		test_random_traffic(RAND_ITEMS, 0, 0);

		$display("Run covered %0d inserts (%0d refused when full) and %0d removes (%0d on empty),",
			n_insert, n_refused, n_remove, n_empty);
		$display("peak fill %0d of %0d, %0d cycles of stalled input, %0d mismatches.",
			peak_fill, DEPTH, input_stalls, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sorted_priority_queue.f =====
+incdir+design
design/srpq_pkg.sv
design/srpq_dp.sv
design/srpq_ctrl.sv
design/sorted_priority_queue.sv
dv/testbench.sv
